[sv/ptbd_pkg.sv]
// ----------------------------------------------------------------------------
// ptbd_pkg
// Shared types and constants for the paper tape binary block deframer.
// ----------------------------------------------------------------------------
package ptbd_pkg;

    localparam int CounterBits = 16;
    localparam int WordBits    = 29;
    localparam int AddrBits    = 18;

    localparam logic [AddrBits-1:0] CountTop = 18'o400000;

    typedef enum logic [2:0] {
        PH_LEADER,
        PH_ADDR,
        PH_COUNT,
        PH_CKSUM,
        PH_DATA,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        KIND_LEADER,
        KIND_LEADER_LAST,
        KIND_ADDR,
        KIND_COUNT,
        KIND_CKSUM,
        KIND_DATA,
        KIND_END
    } kind_t;

    // one assembled word handed from the frame assembler to the block unit
    typedef struct packed {
        logic                valid;
        logic [WordBits-1:0] word;
    } ptbd_word_t;

endpackage

[sv/ptbd_frame_asm.sv]
// ----------------------------------------------------------------------------
// ptbd_frame_asm
// Input register and three-frame word assembly.
// ----------------------------------------------------------------------------
module ptbd_frame_asm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tape_valid,
    output logic              tape_stall,
    input  logic [7:0]        tape_byte,
    input  logic              res_free,
    output ptbd_pkg::ptbd_word_t wd
);
    import ptbd_pkg::*;

    logic                in_valid_reg, in_valid_next;
    logic [7:0]          in_byte_reg;
    logic [1:0]          pos_reg, pos_next;
    logic [WordBits-1:0] asm_reg, asm_next;
    logic                proc;
    logic                punched;
    logic [1:0]          chan;
    logic [5:0]          data;

    assign tape_stall = in_valid_reg && !res_free;
    assign proc       = in_valid_reg && res_free;
    assign punched    = in_byte_reg[7];
    assign chan       = in_byte_reg[7:6];
    assign data       = in_byte_reg[5:0];

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (tape_valid && !tape_stall)
            in_valid_next = 1'b1;
        else if (proc)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        pos_next  = pos_reg;
        asm_next  = asm_reg;
        wd.valid  = 1'b0;
        wd.word   = asm_reg | {6'd0, chan, 15'd0, data};
        if (proc && punched)
        begin
            unique case (pos_reg)
                2'd0:
                begin
                    asm_next = {chan, 9'd0, data, 12'd0};
                    pos_next = 2'd1;
                end
                2'd1:
                begin
                    asm_next = asm_reg | {3'd0, chan, 12'd0, data, 6'd0};
                    pos_next = 2'd2;
                end
                default:
                begin
                    asm_next = wd.word;
                    pos_next = 2'd0;
                    wd.valid = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pos_reg      <= 2'd0;
            asm_reg      <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            pos_reg      <= pos_next;
            asm_reg      <= asm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tape_valid && !tape_stall)
            in_byte_reg <= tape_byte;
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 2'd3)
        else $error("frame position out of range");
    a_word_needs_proc: assert property (@(posedge clk) disable iff (!rst_n)
        wd.valid |-> (proc && punched && pos_reg == 2'd2))
        else $error("word strobe without third punched frame");
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !res_free) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held byte lost while result side blocked");

endmodule

[sv/ptbd_block_unit.sv]
// ----------------------------------------------------------------------------
// ptbd_block_unit
// Leader/block sequencing, checksum, counters and the result register.
// ----------------------------------------------------------------------------
module ptbd_block_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ptbd_pkg::ptbd_word_t       wd,
    output logic                       res_free,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [2:0]                 kind,
    output logic [ptbd_pkg::WordBits-1:0] word,
    output logic [ptbd_pkg::AddrBits-1:0] address,
    output logic                       last_of_block,
    output logic                       checksum_bad,
    output logic [ptbd_pkg::AddrBits-1:0] block_sum,
    output logic [15:0]                blocks_total,
    output logic [15:0]                blocks_bad
);
    import ptbd_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [AddrBits-1:0]    addr_reg, addr_next;
    logic [AddrBits-1:0]    rem_reg, rem_next;
    logic [AddrBits-1:0]    sum_reg, sum_next;
    logic [CounterBits-1:0] tot_reg, tot_next;
    logic [CounterBits-1:0] bad_reg, bad_next;

    logic                   rv_reg, rv_next;
    kind_t                  kind_reg, kind_res;
    logic [WordBits-1:0]    word_reg, word_res;
    logic [AddrBits-1:0]    address_reg, address_res;
    logic                   last_reg, last_res;
    logic                   bad_flag_reg, bad_flag_res;
    logic [AddrBits-1:0]    bsum_reg, bsum_res;
    logic [CounterBits-1:0] tot_out_reg, bad_out_reg;

    logic                   load;
    logic [AddrBits-1:0]    w18;
    logic [AddrBits-1:0]    sum_add;
    logic                   end_of_tape;

    assign res_free    = !rv_reg || !result_stall;
    assign load        = wd.valid && (phase_reg != PH_DONE);
    assign w18         = wd.word[AddrBits-1:0];
    assign sum_add     = sum_reg + w18;
    assign end_of_tape = addr_reg[17:15] != 3'd0;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (wd.valid)
        begin
            unique case (phase_reg)
                PH_LEADER: if (wd.word[21]) phase_next = PH_ADDR;
                PH_ADDR:   phase_next = PH_COUNT;
                PH_COUNT:  phase_next = end_of_tape ? PH_DONE : PH_CKSUM;
                PH_CKSUM:  phase_next = PH_DATA;
                PH_DATA:   if (rem_reg == 18'd1) phase_next = PH_ADDR;
                PH_DONE:   phase_next = PH_DONE;
                default:   phase_next = phase_reg;
            endcase
        end
    end

    // datapath and result fields
    always_comb
    begin
        addr_next    = addr_reg;
        rem_next     = rem_reg;
        sum_next     = sum_reg;
        tot_next     = tot_reg;
        bad_next     = bad_reg;
        kind_res     = KIND_LEADER;
        word_res     = {11'd0, w18};
        address_res  = addr_reg;
        last_res     = 1'b0;
        bad_flag_res = 1'b0;
        bsum_res     = sum_add;
        unique case (phase_reg)
            PH_LEADER:
            begin
                kind_res    = wd.word[21] ? KIND_LEADER_LAST : KIND_LEADER;
                word_res    = wd.word;
                address_res = '0;
                bsum_res    = '0;
            end
            PH_ADDR:
            begin
                addr_next   = w18;
                sum_next    = w18;
                kind_res    = KIND_ADDR;
                address_res = w18;
                bsum_res    = w18;
            end
            PH_COUNT:
            begin
                sum_next = sum_add;
                if (end_of_tape)
                    kind_res = KIND_END;
                else
                begin
                    kind_res = KIND_COUNT;
                    // bit 17 forced, then negated: 1 to 2^17 data words
                    rem_next = CountTop - {1'b0, w18[16:0]};
                end
            end
            PH_CKSUM:
            begin
                sum_next = sum_add;
                kind_res = KIND_CKSUM;
            end
            PH_DATA:
            begin
                sum_next  = sum_add;
                addr_next = addr_reg + 18'd1;
                rem_next  = rem_reg - 18'd1;
                kind_res  = KIND_DATA;
                if (rem_reg == 18'd1)
                begin
                    last_res     = 1'b1;
                    bad_flag_res = sum_add != '0;
                    tot_next     = tot_reg + CounterBits'(1);
                    if (sum_add != '0)
                        bad_next = bad_reg + CounterBits'(1);
                end
            end
            default:
            begin
                kind_res = KIND_END;
            end
        endcase
    end

    always_comb
    begin
        rv_next = rv_reg;
        if (load)
            rv_next = 1'b1;
        else if (rv_reg && !result_stall)
            rv_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEADER;
            addr_reg  <= '0;
            rem_reg   <= '0;
            sum_reg   <= '0;
            tot_reg   <= '0;
            bad_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            rv_reg    <= rv_next;
            if (load)
            begin
                addr_reg <= addr_next;
                rem_reg  <= rem_next;
                sum_reg  <= sum_next;
                tot_reg  <= tot_next;
                bad_reg  <= bad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg     <= kind_res;
            word_reg     <= word_res;
            address_reg  <= address_res;
            last_reg     <= last_res;
            bad_flag_reg <= bad_flag_res;
            bsum_reg     <= bsum_res;
            tot_out_reg  <= tot_next;
            bad_out_reg  <= bad_next;
        end
    end

    assign result_valid  = rv_reg;
    assign kind          = kind_reg;
    assign word          = word_reg;
    assign address       = address_reg;
    assign last_of_block = last_reg;
    assign checksum_bad  = bad_flag_reg;
    assign block_sum     = bsum_reg;
    assign blocks_total  = 16'(tot_out_reg);
    assign blocks_bad    = 16'(bad_out_reg);

    a_no_load_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && result_stall) |-> !load)
        else $error("result overwritten while stalled");
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |-> !load)
        else $error("result after end of tape");
    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && last_reg) |-> (kind_reg == KIND_DATA))
        else $error("block end flag on non-data word");
    a_bad_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && bad_flag_reg) |-> last_reg)
        else $error("checksum flag away from block end");

endmodule

[sv/paper_tape_binary_block_deframer_core.sv]
// ----------------------------------------------------------------------------
// paper_tape_binary_block_deframer_core
// Packs punched tape frames into words and splits the binary loader
// stream into leader, block header, data and end-of-tape results.
// ----------------------------------------------------------------------------
//  channel | handshake                   | payload
//  --------+-----------------------------+-----------------------------------
//  tape    | tape_valid / tape_stall     | tape_byte
//  result  | result_valid / result_stall | kind, word, address, last_of_block,
//          |                             | checksum_bad, block_sum,
//          |                             | blocks_total, blocks_bad
//
//  One byte per cycle while the result is not stalled: input register, one
//  level of state update, result register. A byte that completes a word is
//  held in the input register, and its result is presented from the result register.
//  Reset (async, active low) returns to the leader phase with counters clear.
//  A stalled result holds; one more byte is taken into the input register,
//  then tape_stall rises until the result moves.
//  After end of tape, bytes are taken and dropped until reset.
// ----------------------------------------------------------------------------
module paper_tape_binary_block_deframer_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tape_valid,
    output logic                       tape_stall,
    input  logic [7:0]                 tape_byte,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [2:0]                 kind,
    output logic [ptbd_pkg::WordBits-1:0] word,
    output logic [ptbd_pkg::AddrBits-1:0] address,
    output logic                       last_of_block,
    output logic                       checksum_bad,
    output logic [ptbd_pkg::AddrBits-1:0] block_sum,
    output logic [15:0]                blocks_total,
    output logic [15:0]                blocks_bad
);
    import ptbd_pkg::*;

    ptbd_word_t wd;
    logic       res_free;

    ptbd_frame_asm u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .tape_valid (tape_valid),
        .tape_stall (tape_stall),
        .tape_byte  (tape_byte),
        .res_free   (res_free),
        .wd         (wd)
    );

    ptbd_block_unit u_block (
        .clk           (clk),
        .rst_n         (rst_n),
        .wd            (wd),
        .res_free      (res_free),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .kind          (kind),
        .word          (word),
        .address       (address),
        .last_of_block (last_of_block),
        .checksum_bad  (checksum_bad),
        .block_sum     (block_sum),
        .blocks_total  (blocks_total),
        .blocks_bad    (blocks_bad)
    );

endmodule
